FILE: hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the sigma functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned WordWidth  = 32;
	localparam int unsigned NumRounds  = 64;
	localparam int unsigned SchedDepth = 16;
	localparam int unsigned HashWords  = 8;

	typedef logic [WordWidth-1:0] word_t;

	localparam word_t KTable [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t IvTable [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WordWidth - n));
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t ssig0(input word_t x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

FILE: hw/rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Absorbs a message byte by byte, pads it and returns the digest as words.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one item per transfer: data_byte with byte_valid,
// and end_of_message on the last item. A byte transfer that does not complete
// a block is taken without a stall. The 16-word block buffer lives in a
// synchronous memory with one write and one read port, registered data.
// A full block starts the compression. Each round reads four schedule words
// through the single read port (ST_RD), forms the schedule word (ST_ROUND)
// and runs the round itself (ST_FOLD). A final step (ST_SUM) adds the working
// variables into the hash; in_stall is high throughout the compression.
// On end_of_message the block inserts the pad byte, zero fill and bit length
// itself, one byte per cycle between compressions, and compresses one or two
// blocks; it then returns eight transfers of digest_word, index 0 first,
// last_word on index 7. in_stall stays high from the end mark until the
// eighth word has left. While out_stall is high, the word holds and the block
// waits. Reset clears the control state and loads the initial hash.
// ----------------------------------------------------------------------------
module sha256_message_hasher
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_RD,
		ST_ROUND,
		ST_FOLD,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t      state_q;
	word_t       hash_q [HashWords];
	word_t       var_q [HashWords];
	logic [63:0] bit_count_q;
	logic [63:0] len_q;
	logic [5:0]  pos_q;
	logic [6:0]  round_q;
	logic [1:0]  phase_q;
	logic        padding_q;
	logic        ending_q;
	logic        wrap_q;
	logic        len_written_q;
	logic [2:0]  out_idx_q;
	word_t       acc_q;
	word_t       w15_q;
	word_t       w2_q;
	word_t       w7_q;
	word_t       w_q;

	// Block buffer and rolling schedule memory.
	word_t       mem [SchedDepth];
	logic        mem_we;
	logic [3:0]  mem_waddr;
	word_t       mem_wdata;
	logic [3:0]  mem_raddr;
	word_t       mem_rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	// Byte currently being absorbed: message byte or padding byte.
	logic       absorb;
	logic [7:0] abs_byte;
	logic [7:0] pad_byte;
	word_t      word_next;
	logic [5:0] pos_next;
	logic       wrap_now;

	// The pad byte comes first; the length goes in the last eight bytes of the
	// block, unless the pad byte itself landed there and pushed it one block on.
	always_comb begin
		pad_byte = 8'h00;
		if (!padding_q) begin
			pad_byte = 8'h80;
		end else if (pos_q >= 6'd56 && !wrap_q) begin
			pad_byte = len_q[{3'd7 - pos_q[2:0], 3'b000} +: 8];
		end
	end

	assign absorb   = (state_q == ST_IDLE && in_valid && byte_valid) || (state_q == ST_PAD);
	assign abs_byte = (state_q == ST_PAD) ? pad_byte : data_byte;
	assign pos_next = pos_q + 6'd1;
	assign wrap_now = wrap_q || (!padding_q && pos_q >= 6'd56);

	always_comb begin
		word_next = (pos_q[1:0] == 2'd0) ? 32'd0 : acc_q;
		word_next[{2'd3 - pos_q[1:0], 3'b000} +: 8] = abs_byte;
	end

	// Round datapath.
	word_t t1;
	word_t t2;
	word_t w_new;

	assign w_new = ssig1(w2_q) + w7_q + ssig0(w15_q) + mem_rdata_q;
	always_comb begin
		t1 = var_q[7] + bsig1(var_q[4]) + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
			+ KTable[round_q[5:0]] + w_q;
		t2 = bsig0(var_q[0]) + ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2])
			^ (var_q[1] & var_q[2]));
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[5:2];
		mem_wdata = word_next;
		mem_raddr = round_q[3:0];
		if (absorb && pos_q[1:0] == 2'd3) begin
			mem_we = 1'b1;
		end
		if (state_q == ST_RD) begin
			case (phase_q)
				2'd0:    mem_raddr = round_q[3:0] - 4'd15;
				2'd1:    mem_raddr = round_q[3:0] - 4'd2;
				2'd2:    mem_raddr = round_q[3:0] - 4'd7;
				default: mem_raddr = round_q[3:0];
			endcase
		end
		if (state_q == ST_ROUND && round_q >= 7'd16) begin
			mem_we    = 1'b1;
			mem_waddr = round_q[3:0];
			mem_wdata = w_new;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = hash_q[out_idx_q];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == 3'd7);

	// Sequencer: absorb, pad, rounds, fold and digest output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_count_q <= '0;
			len_q       <= '0;
			pos_q       <= '0;
			round_q     <= '0;
			phase_q     <= '0;
			padding_q   <= 1'b0;
			ending_q    <= 1'b0;
			out_idx_q   <= '0;
			acc_q       <= '0;
			w15_q       <= '0;
			w2_q        <= '0;
			w7_q        <= '0;
			w_q         <= '0;
			for (int i = 0; i < HashWords; i++) begin
				hash_q[i] <= IvTable[i];
				var_q[i]  <= '0;
			end
		end else begin
			if (absorb) begin
				acc_q <= word_next;
				pos_q <= pos_next;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (byte_valid) begin
							bit_count_q <= bit_count_q + 64'd8;
						end
						if (end_of_message) begin
							len_q     <= bit_count_q + (byte_valid ? 64'd8 : 64'd0);
							ending_q  <= 1'b1;
							padding_q <= 1'b0;
						end
						if (byte_valid && pos_next == 6'd0) begin
							state_q <= ST_RD;
							round_q <= '0;
							phase_q <= '0;
							for (int i = 0; i < HashWords; i++) begin
								var_q[i] <= hash_q[i];
							end
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					padding_q <= 1'b1;
					if (pos_next == 6'd0) begin
						state_q <= ST_RD;
						round_q <= '0;
						phase_q <= '0;
						for (int i = 0; i < HashWords; i++) begin
							var_q[i] <= hash_q[i];
						end
					end
				end
				ST_RD: begin
					phase_q <= phase_q + 2'd1;
					case (phase_q)
						2'd1:    w15_q <= mem_rdata_q;
						2'd2:    w2_q  <= mem_rdata_q;
						2'd3:    w7_q  <= mem_rdata_q;
						default: ;
					endcase
					if (phase_q == 2'd3) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					// The read data now holds the window word of this round.
					w_q     <= (round_q < 7'd16) ? mem_rdata_q : w_new;
					state_q <= ST_FOLD;
					phase_q <= 2'd0;
				end
				ST_FOLD: begin
					// One SHA-256 round with the word now held in w_q.
					var_q[7] <= var_q[6];
					var_q[6] <= var_q[5];
					var_q[5] <= var_q[4];
					var_q[4] <= var_q[3] + t1;
					var_q[3] <= var_q[2];
					var_q[2] <= var_q[1];
					var_q[1] <= var_q[0];
					var_q[0] <= t1 + t2;
					if (round_q == 7'(NumRounds - 1)) begin
						round_q <= '0;
						state_q <= ST_SUM;
					end else begin
						round_q <= round_q + 7'd1;
						state_q <= ST_RD;
					end
				end
				ST_SUM: begin
					// Add the working variables into the hash and pick what follows.
					for (int i = 0; i < HashWords; i++) begin
						hash_q[i] <= hash_q[i] + var_q[i];
					end
					out_idx_q <= '0;
					if (!ending_q) begin
						state_q <= ST_IDLE;
					end else if (len_written_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							state_q     <= ST_IDLE;
							ending_q    <= 1'b0;
							padding_q   <= 1'b0;
							bit_count_q <= '0;
							pos_q       <= '0;
							for (int i = 0; i < HashWords; i++) begin
								hash_q[i] <= IvTable[i];
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The final block is the one whose length field was written. A pad byte in
	// the last eight bytes of a block moves the length to the next block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_written_q <= 1'b0;
			wrap_q        <= 1'b0;
		end else begin
			if (state_q == ST_OUT && !out_stall && out_idx_q == 3'd7) begin
				len_written_q <= 1'b0;
			end else if (state_q == ST_PAD && pos_q == 6'd63 && !wrap_now) begin
				len_written_q <= 1'b1;
			end
			if (state_q == ST_PAD && pos_q == 6'd63) begin
				wrap_q <= 1'b0;
			end else if (state_q == ST_PAD && wrap_now) begin
				wrap_q <= 1'b1;
			end
		end
	end

endmodule
